@@ rtl/sawc_pkg.sv @@
// Shared sizes, row layout and result type of the set-associative cache tag controller.
package sawc_pkg;

    localparam int WAY_COUNT  = 8;
    localparam int SET_COUNT  = 128;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_BITS  = 32;

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int SET_W = $clog2(SET_COUNT);
    localparam int TAG_W = ADDR_BITS - OFF_W - SET_W;
    localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int CNT_W = WAY_W + 1;

    typedef logic [SET_W-1:0] t_set;
    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [WAY_W-1:0] t_way;

    typedef struct packed {
        logic [WAY_COUNT-1:0]            vld;
        logic [WAY_COUNT-1:0]            dirty;
        logic [WAY_COUNT-1:0][TAG_W-1:0] tag;
        logic [WAY_COUNT-1:0][WAY_W-1:0] rank;
    } t_row;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic        writeback;
        logic [31:0] writeback_addr;
        logic        fill;
        logic        done_code;
    } t_result;

endpackage

@@ rtl/sawc_tag_ram.sv @@
// Per-set tag and state memory with row valid flags and write-to-read forwarding.
module sawc_tag_ram
    import sawc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rd_en,
    input  t_set i_rd_set,
    output t_row o_rd_row,
    input  logic i_wr_en,
    input  t_set i_wr_set,
    input  t_row i_wr_row
);

    t_row                 mem [SET_COUNT];
    t_row                 r_rdata;
    t_set                 r_rd_set;
    logic [SET_COUNT-1:0] r_row_vld;
    t_row                 r_fwd_row;
    t_set                 r_fwd_set;
    logic                 r_fwd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rdata  <= mem[i_rd_set];
            r_rd_set <= i_rd_set;
        end
        if (i_wr_en) begin
            r_fwd_row <= i_wr_row;
            r_fwd_set <= i_wr_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_set] <= 1'b1;
            r_fwd_vld           <= 1'b1;
        end
    end

    // The most recent write may have landed at the same edge as the read.
    always_comb begin
        if (r_fwd_vld && (r_fwd_set == r_rd_set)) begin
            o_rd_row = r_fwd_row;
        end else if (!r_row_vld[r_rd_set]) begin
            o_rd_row = '0;
        end else begin
            o_rd_row = r_rdata;
        end
    end

endmodule

@@ rtl/sawc_update.sv @@
// Tag compare, victim choice, LRU rank update and result formation for one set.
module sawc_update
    import sawc_pkg::*;
(
    input  t_row    i_row,
    input  logic    i_is_write,
    input  t_tag    i_tag,
    input  t_set    i_set,
    output t_row    o_row,
    output t_result o_result
);

    logic                 hit;
    t_way                 hit_way;
    logic                 inval_found;
    t_way                 inval_way;
    t_way                 lru_way;
    t_way                 victim;
    t_way                 sel;
    logic                 was_valid;
    logic [WAY_COUNT-1:0] new_vld;
    logic [CNT_W-1:0]     cnt;
    t_way                 top_rank;
    t_way                 old_rank;
    logic                 wb;
    logic [ADDR_BITS-1:0] wb_full;

    always_comb begin
        hit         = 1'b0;
        hit_way     = '0;
        inval_found = 1'b0;
        inval_way   = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (i_row.vld[w] && (i_row.tag[w] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!i_row.vld[w]) begin
                inval_found = 1'b1;
                inval_way   = WAY_W'(w);
            end
        end
        lru_way = '0;
        for (int w = 1; w < WAY_COUNT; w++) begin
            if (i_row.rank[w] < i_row.rank[lru_way]) begin
                lru_way = WAY_W'(w);
            end
        end
    end

    assign victim    = inval_found ? inval_way : lru_way;
    assign sel       = hit ? hit_way : victim;
    assign was_valid = i_row.vld[sel];
    assign wb        = !hit && i_row.vld[victim] && i_row.dirty[victim];

    always_comb begin
        new_vld      = i_row.vld;
        new_vld[sel] = 1'b1;
    end

    assign cnt      = CNT_W'($countones(new_vld));
    assign top_rank = WAY_W'(cnt - 1'b1);
    assign old_rank = was_valid ? i_row.rank[sel] : top_rank;

    always_comb begin
        o_row     = i_row;
        o_row.vld = new_vld;
        for (int v = 0; v < WAY_COUNT; v++) begin
            if ((WAY_W'(v) != sel) && new_vld[v] && (i_row.rank[v] > old_rank)) begin
                o_row.rank[v] = i_row.rank[v] - 1'b1;
            end
        end
        o_row.rank[sel] = top_rank;
        if (hit) begin
            o_row.dirty[sel] = i_row.dirty[sel] | i_is_write;
        end else begin
            o_row.dirty[sel] = i_is_write;
            o_row.tag[sel]   = i_tag;
        end
    end

    assign wb_full = {i_row.tag[victim], i_set, {OFF_W{1'b0}}};

    always_comb begin
        o_result.hit            = hit;
        o_result.way            = 3'(sel);
        o_result.writeback      = wb;
        o_result.writeback_addr = wb ? 32'(wb_full) : 32'd0;
        o_result.fill           = !hit;
        o_result.done_code      = i_is_write;
    end

endmodule

@@ rtl/set_assoc_writeback_cache_tags_top.sv @@
// Top level of the 8-way write-back cache tag and state controller.
// A request is transferred in and its set row is read from the tag memory at that edge; the
// hit check, victim choice and LRU update then run and the result is registered when the
// output stage can take it. A new request is taken every cycle while the output is not stalled,
// back-to-back requests to the same set being served by forwarding the row just written.
// Valid, dirty and LRU state read as cleared after reset through per-set row flags, so no
// clearing pass is needed and requests are taken from the first cycle after reset.
module set_assoc_writeback_cache_tags_top
    import sawc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic [2:0]  o_way,
    output logic        o_writeback,
    output logic [31:0] o_writeback_addr,
    output logic        o_fill,
    output logic        o_done_code
);

    logic    r_s_vld;
    logic    r_s_write;
    t_tag    r_s_tag;
    t_set    r_s_set;
    logic    r_o_vld;
    t_result r_o;

    logic    accept;
    logic    advance;
    t_set    in_set;
    t_row    rd_row;
    t_row    wr_row;
    t_result n_result;

    assign in_set  = i_address[OFF_W +: SET_W];
    assign advance = r_s_vld && (!r_o_vld || !i_stall);
    assign o_stall = r_s_vld && !advance;
    assign accept  = i_valid && !o_stall;

    sawc_tag_ram u_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_set (in_set),
        .o_rd_row (rd_row),
        .i_wr_en  (advance),
        .i_wr_set (r_s_set),
        .i_wr_row (wr_row)
    );

    sawc_update u_upd (
        .i_row      (rd_row),
        .i_is_write (r_s_write),
        .i_tag      (r_s_tag),
        .i_set      (r_s_set),
        .o_row      (wr_row),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s_vld <= 1'b1;
            end else if (advance) begin
                r_s_vld <= 1'b0;
            end
            if (advance) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_write <= i_req_type;
            r_s_tag   <= i_address[ADDR_BITS-1 -: TAG_W];
            r_s_set   <= in_set;
        end
        if (advance) begin
            r_o <= n_result;
        end
    end

    assign o_valid          = r_o_vld;
    assign o_hit            = r_o.hit;
    assign o_way            = r_o.way;
    assign o_writeback      = r_o.writeback;
    assign o_writeback_addr = r_o.writeback_addr;
    assign o_fill           = r_o.fill;
    assign o_done_code      = r_o.done_code;

endmodule

@@ rtl/sawc_checker.sv @@
// Port-level assertions for the cache tag controller and their binding to the top level.
module sawc_checker
    import sawc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_req_type,
    input logic [31:0] i_address,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic [2:0]  o_way,
    input logic        o_writeback,
    input logic [31:0] o_writeback_addr,
    input logic        o_fill,
    input logic        o_done_code
);

    a_hit_xor_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit != o_fill))
        else $error("A result must be either a hit or a fill.");

    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_writeback) |-> (o_fill && (o_writeback_addr[OFF_W-1:0] == '0)))
        else $error("A writeback must come with a fill and a line-aligned address.");

    a_wb_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writeback) |-> (o_writeback_addr == 32'd0))
        else $error("The writeback address must be zero without a writeback.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_way) && $stable(o_hit)
            && $stable(o_writeback) && $stable(o_writeback_addr)
            && $stable(o_fill) && $stable(o_done_code)))
        else $error("A stalled result transfer must hold.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_req_type) && $stable(i_address)))
        else $error("A stalled request transfer must hold.");

endmodule

bind set_assoc_writeback_cache_tags_top sawc_checker u_sawc_checker (.*);

@@ verif/set_assoc_writeback_cache_tags_top_test.sv @@
// Self-checking testbench for the 8-way cache tag controller: directed table, then random.
module set_assoc_writeback_cache_tags_top_test
    import sawc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_READ   = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;
    localparam logic DONE_READ  = 1'b0;
    localparam logic DONE_WRITE = 1'b1;
    localparam int   N_PROBES   = 23;
    localparam int   N_PHASES   = 4;
    localparam int   PHASE_REQS = 345;

    typedef struct {
        logic        wr;
        logic [31:0] addr;
        logic        typed;
        t_result     res;
    } t_probe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = REQ_READ;
    logic [31:0] i_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_hit;
    logic [2:0]  o_way;
    logic        o_writeback;
    logic [31:0] o_writeback_addr;
    logic        o_fill;
    logic        o_done_code;

    logic             line_vld   [SET_COUNT][WAY_COUNT];
    logic             line_dirty [SET_COUNT][WAY_COUNT];
    t_tag             line_tag   [SET_COUNT][WAY_COUNT];
    logic [WAY_W-1:0] line_rank  [SET_COUNT][WAY_COUNT];

    t_result pending_results[$];
    int      mismatch_cnt = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;

    // Rows with a typed result: first access after reset, address extremes and the
    // eviction of a dirty line at the top of the address space.
    t_probe probes [N_PROBES] = '{
        '{REQ_READ,  32'h0000_0000, 1'b1, {1'b0, 3'd0, 1'b0, 32'h0, 1'b1, DONE_READ}},
        '{REQ_WRITE, 32'hFFFF_FFFF, 1'b1, {1'b0, 3'd0, 1'b0, 32'h0, 1'b1, DONE_WRITE}},
        '{REQ_READ,  32'hFFFF_FFE0, 1'b1, {1'b1, 3'd0, 1'b0, 32'h0, 1'b0, DONE_READ}},
        '{REQ_WRITE, 32'h0000_001F, 1'b1, {1'b1, 3'd0, 1'b0, 32'h0, 1'b0, DONE_WRITE}},
        '{REQ_WRITE, 32'h0000_1000, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_2000, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_3000, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_4000, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_5000, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_6000, 1'b0, '0},
        '{REQ_WRITE, 32'h0000_7000, 1'b0, '0},
        '{REQ_READ,  32'h0000_8000, 1'b0, '0},
        '{REQ_READ,  32'h0000_1004, 1'b0, '0},
        '{REQ_READ,  32'h0000_9000, 1'b0, '0},
        '{REQ_WRITE, 32'hFFFF_F000, 1'b0, '0},
        '{REQ_READ,  32'h8000_0FE0, 1'b0, '0},
        '{REQ_WRITE, 32'h8000_1FE0, 1'b0, '0},
        '{REQ_READ,  32'h8000_2FE0, 1'b0, '0},
        '{REQ_WRITE, 32'h8000_3FE0, 1'b0, '0},
        '{REQ_READ,  32'h8000_4FE0, 1'b0, '0},
        '{REQ_WRITE, 32'h8000_5FE0, 1'b0, '0},
        '{REQ_READ,  32'h8000_6FE0, 1'b0, '0},
        '{REQ_READ,  32'h8000_7FE0, 1'b1, {1'b0, 3'd0, 1'b1, 32'hFFFF_FFE0, 1'b1, DONE_READ}}
    };

    set_assoc_writeback_cache_tags_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_address        (i_address),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hit            (o_hit),
        .o_way            (o_way),
        .o_writeback      (o_writeback),
        .o_writeback_addr (o_writeback_addr),
        .o_fill           (o_fill),
        .o_done_code      (o_done_code)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result cache_lookup(logic wr, logic [31:0] addr);
        t_set    s;
        t_tag    tg;
        int      w;
        int      hit_way;
        int      cnt;
        int      old;
        logic    was_vld;
        t_result r;
        s = addr[OFF_W +: SET_W];
        tg = addr[OFF_W + SET_W +: TAG_W];
        r = '0;
        hit_way = -1;
        for (int v = 0; v < WAY_COUNT; v++) begin
            if (hit_way < 0 && line_vld[s][v] && line_tag[s][v] == tg) begin
                hit_way = v;
            end
        end
        if (hit_way >= 0) begin
            w = hit_way;
            was_vld = 1'b1;
            if (wr == REQ_WRITE) begin
                line_dirty[s][w] = 1'b1;
            end
        end else begin
            w = -1;
            for (int v = 0; v < WAY_COUNT; v++) begin
                if (w < 0 && !line_vld[s][v]) begin
                    w = v;
                end
            end
            if (w < 0) begin
                w = 0;
                for (int v = 1; v < WAY_COUNT; v++) begin
                    if (line_rank[s][v] < line_rank[s][w]) begin
                        w = v;
                    end
                end
            end
            was_vld = line_vld[s][w];
            if (was_vld && line_dirty[s][w]) begin
                r.writeback = 1'b1;
                r.writeback_addr = {line_tag[s][w], s, {OFF_W{1'b0}}};
            end
            line_vld[s][w] = 1'b1;
            line_tag[s][w] = tg;
            line_dirty[s][w] = (wr == REQ_WRITE);
        end
        cnt = 0;
        for (int v = 0; v < WAY_COUNT; v++) begin
            if (line_vld[s][v]) begin
                cnt++;
            end
        end
        old = was_vld ? int'(line_rank[s][w]) : cnt - 1;
        for (int v = 0; v < WAY_COUNT; v++) begin
            if (v != w && line_vld[s][v] && int'(line_rank[s][v]) > old) begin
                line_rank[s][v] = line_rank[s][v] - 1'b1;
            end
        end
        line_rank[s][w] = WAY_W'(cnt - 1);
        r.hit = (hit_way >= 0);
        r.way = 3'(w);
        r.fill = (hit_way < 0);
        r.done_code = (wr == REQ_WRITE) ? DONE_WRITE : DONE_READ;
        return r;
    endfunction

    task automatic note_error(string what, t_result e, t_result g);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t %s: exp hit=%b way=%0d wb=%b wba=%h fill=%b done=%b", $realtime, what,
                     e.hit, e.way, e.writeback, e.writeback_addr, e.fill, e.done_code);
            $display("%0t %s: got hit=%b way=%0d wb=%b wba=%h fill=%b done=%b", $realtime, what,
                     g.hit, g.way, g.writeback, g.writeback_addr, g.fill, g.done_code);
        end
    endtask

    task automatic send_req(logic wr, logic [31:0] addr, logic typed, t_result typed_res);
        t_result pred;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= wr;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
        pred = cache_lookup(wr, addr);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_hit, o_way, o_writeback, o_writeback_addr, o_fill, o_done_code};
            if (pending_results.size() == 0) begin
                note_error("unexpected transfer", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.way !== want.way
                        || got.writeback !== want.writeback
                        || got.writeback_addr !== want.writeback_addr
                        || got.fill !== want.fill || got.done_code !== want.done_code) begin
                    note_error("mismatch", want, got);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int          src_pct [N_PHASES];
        int          snk_pct [N_PHASES];
        t_set        hot_set [3];
        t_tag        hot_tag [12];
        logic [31:0] addr;
        src_pct = '{0, 56, 0, 12};
        snk_pct = '{0, 0, 56, 12};
        for (int s = 0; s < SET_COUNT; s++) begin
            for (int w = 0; w < WAY_COUNT; w++) begin
                line_vld[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_tag[s][w] = '0;
                line_rank[s][w] = '0;
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_PROBES; k++) begin
            send_req(probes[k].wr, probes[k].addr, probes[k].typed, probes[k].res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            src_idle_pct = src_pct[ph];
            snk_stall_pct = snk_pct[ph];
            foreach (hot_set[k]) hot_set[k] = t_set'($urandom);
            foreach (hot_tag[k]) hot_tag[k] = t_tag'($urandom);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(99) < 80) begin
                    addr = {hot_tag[$urandom_range(11)], hot_set[$urandom_range(2)],
                            OFF_W'($urandom)};
                end else begin
                    addr = $urandom;
                end
                send_req($urandom_range(1) ? REQ_WRITE : REQ_READ, addr, 1'b0, '0);
            end
            i_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
